@@ hdl/rsbg_pkg.sv @@
// ----------------------------------------------------------------------------
// rsbg_pkg
// Types and constants shared by the ramped square beep generator: the
// command and sample item layouts and the configuration register map.
// ----------------------------------------------------------------------------
package rsbg_pkg;

  // Command item: a sample tick or a play request.
  typedef struct packed {
    logic operation;
    logic sound;
  } cmd_t;

  // Sample item: one audio sample and whether it belongs to a beep.
  typedef struct packed {
    logic signed [15:0] sample;
    logic               busy_res;
  } smp_t;

  // Command codes.
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_PLAY = 1'b1;

  // Click selection codes.
  localparam logic SOUND_MOVE  = 1'b0;
  localparam logic SOUND_PRESS = 1'b1;

  // Configuration port geometry.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MOVE_HALF_PERIOD  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MOVE_LENGTH       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_HALF_PERIOD = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_LENGTH      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE         = 3'd4;

  // Field widths.
  localparam int unsigned HP_W  = 12;
  localparam int unsigned LEN_W = 16;
  localparam int unsigned AMP_W = 15;

  // Register values after reset.
  localparam logic [HP_W-1:0]  RST_MOVE_HALF_PERIOD  = 12'd11;
  localparam logic [LEN_W-1:0] RST_MOVE_LENGTH       = 16'd220;
  localparam logic [HP_W-1:0]  RST_PRESS_HALF_PERIOD = 12'd7;
  localparam logic [LEN_W-1:0] RST_PRESS_LENGTH      = 16'd352;
  localparam logic [AMP_W-1:0] RST_AMPLITUDE         = 15'd4200;

  // Pending click codes.
  localparam logic [1:0] PEND_NONE  = 2'd0;
  localparam logic [1:0] PEND_MOVE  = 2'd1;
  localparam logic [1:0] PEND_PRESS = 2'd2;

endpackage

@@ hdl/ramped_square_beep_generator_core.sv @@
// ----------------------------------------------------------------------------
// ramped_square_beep_generator_core
// Square-wave click generator with a linear fade in and fade out. Play
// requests latch a pending click; each sample tick yields one sample item.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake             Payload
//  cmd      in         cmd_valid / cmd_stall rsbg_pkg::cmd_t (operation, sound)
//  smp      out        smp_valid / smp_stall rsbg_pkg::smp_t (sample, busy_res)
//  cfg      in         cfg_write             cfg_index, cfg_data
//
//  A play request is absorbed in the cycle it is accepted and gives no item.
//  A sample tick passes ST_EVAL, which evaluates position and ramps, then
//  ST_MUL and ST_DIV of the shared multiplier per ramp scaling (product, then
//  reciprocal multiply for the division by RAMP_LEN), then ST_OUT to issue.
//  cmd_stall is high while a tick is in progress or its sample waits on a
//  stalled output register. Reset (rst, synchronous) restores the register
//  defaults and leaves no click pending or playing.
//
module ramped_square_beep_generator_core #(
  parameter int unsigned RAMP_LEN = 40
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cmd_valid,
  output logic                                cmd_stall,
  input  rsbg_pkg::cmd_t                      cmd,
  output logic                                smp_valid,
  input  logic                                smp_stall,
  output rsbg_pkg::smp_t                      smp,
  input  logic                                cfg_write,
  input  logic [rsbg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rsbg_pkg::CFG_DATA_W-1:0]     cfg_data
);

  // Ramp factors stay below RAMP_LEN, so FW bits hold them.
  localparam int unsigned FW  = $clog2(RAMP_LEN + 1);
  localparam int unsigned P_W = rsbg_pkg::AMP_W + FW;
  // Reciprocal scale: exact truncating quotient for every product below 2^P_W.
  localparam int unsigned K   = P_W + FW;
  localparam int unsigned M_W = K + 1;
  localparam logic [63:0] RECIP_WIDE =
    ((64'd1 << K) + 64'(RAMP_LEN) - 64'd1) / 64'(RAMP_LEN);
  localparam logic [M_W-1:0] RECIP = RECIP_WIDE[M_W-1:0];
  localparam logic [rsbg_pkg::LEN_W-1:0] RAMP = rsbg_pkg::LEN_W'(RAMP_LEN);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_MUL,
    ST_DIV,
    ST_OUT
  } state_t;

  state_t state;

  // Configuration registers.
  logic [rsbg_pkg::HP_W-1:0]  move_half_period;
  logic [rsbg_pkg::LEN_W-1:0] move_length;
  logic [rsbg_pkg::HP_W-1:0]  press_half_period;
  logic [rsbg_pkg::LEN_W-1:0] press_length;
  logic [rsbg_pkg::AMP_W-1:0] amplitude;

  // Beep state.
  logic [1:0]                 pending_sound;
  logic                       playing;
  logic                       active_sound;
  logic [rsbg_pkg::LEN_W-1:0] position;
  logic [rsbg_pkg::HP_W-1:0]  half_period_count;
  logic                       wave_phase;

  // Working registers of the current tick.
  logic                       silent;
  logic                       do_in;
  logic                       do_out;
  logic [FW-1:0]              tail;
  logic [rsbg_pkg::AMP_W-1:0] mag;
  logic [P_W-1:0]             prod;

  // Combinational helpers.
  logic [rsbg_pkg::LEN_W-1:0] len_sel;
  logic [rsbg_pkg::HP_W-1:0]  hp_sel;
  logic [rsbg_pkg::HP_W-1:0]  hp_eff;
  logic [rsbg_pkg::LEN_W-1:0] remain;
  logic [rsbg_pkg::LEN_W-1:0] pos_inc;
  logic [rsbg_pkg::HP_W-1:0]  hpc_inc;
  logic                       hpc_wrap;
  logic [P_W-1:0]             mul_a;
  logic [M_W-1:0]             mul_b;
  logic [P_W+M_W-1:0]         mul_out;
  logic [FW-1:0]              factor;
  logic signed [15:0]         wave_value;

  assign cmd_stall = (state != ST_IDLE);

  // Parameters of the click being played, and the per-sample increments.
  always_comb begin
    len_sel  = active_sound ? press_length : move_length;
    hp_sel   = active_sound ? press_half_period : move_half_period;
    hp_eff   = (hp_sel == '0) ? rsbg_pkg::HP_W'(1) : hp_sel;
    remain   = len_sel - position;
    pos_inc  = position + rsbg_pkg::LEN_W'(1);
    hpc_inc  = half_period_count + rsbg_pkg::HP_W'(1);
    hpc_wrap = (hpc_inc >= hp_eff) || (hpc_inc == '0);
  end

  // Shared multiplier: amplitude times ramp factor, then product times
  // the reciprocal of RAMP_LEN.
  always_comb begin
    factor = do_in ? position[FW-1:0] : tail;
    if (state == ST_DIV) begin
      mul_a = prod;
      mul_b = RECIP;
    end else begin
      mul_a = P_W'(mag);
      mul_b = M_W'(factor);
    end
    mul_out = (P_W+M_W)'(mul_a) * (P_W+M_W)'(mul_b);
  end

  // Signed sample from phase and magnitude.
  always_comb begin
    if (wave_phase) begin
      wave_value = signed'({1'b0, mag});
    end else begin
      wave_value = signed'(16'd0 - {1'b0, mag});
    end
  end

  // Sequencer, configuration and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      move_half_period  <= rsbg_pkg::RST_MOVE_HALF_PERIOD;
      move_length       <= rsbg_pkg::RST_MOVE_LENGTH;
      press_half_period <= rsbg_pkg::RST_PRESS_HALF_PERIOD;
      press_length      <= rsbg_pkg::RST_PRESS_LENGTH;
      amplitude         <= rsbg_pkg::RST_AMPLITUDE;
      pending_sound     <= rsbg_pkg::PEND_NONE;
      playing           <= 1'b0;
      active_sound      <= rsbg_pkg::SOUND_MOVE;
      position          <= '0;
      half_period_count <= '0;
      wave_phase        <= 1'b0;
      silent            <= 1'b1;
      do_in             <= 1'b0;
      do_out            <= 1'b0;
      smp_valid         <= 1'b0;
    end else begin
      // Register writes must arrive only while the block is idle; the block itself does not enforce it.
      if (cfg_write) begin
        unique case (cfg_index)
          rsbg_pkg::CFG_MOVE_HALF_PERIOD:  move_half_period  <= cfg_data[rsbg_pkg::HP_W-1:0];
          rsbg_pkg::CFG_MOVE_LENGTH:       move_length       <= cfg_data;
          rsbg_pkg::CFG_PRESS_HALF_PERIOD: press_half_period <= cfg_data[rsbg_pkg::HP_W-1:0];
          rsbg_pkg::CFG_PRESS_LENGTH:      press_length      <= cfg_data;
          rsbg_pkg::CFG_AMPLITUDE:         amplitude         <= cfg_data[rsbg_pkg::AMP_W-1:0];
          default: ;
        endcase
      end

      // The output register empties when its item is taken, unless the
      // issue state refills it in the same cycle.
      if (smp_valid && !smp_stall && state != ST_OUT) begin
        smp_valid <= 1'b0;
      end

      unique case (state)
        // Take a command; requests are absorbed here, ticks start a sample.
        ST_IDLE: begin
          if (cmd_valid) begin
            if (cmd.operation == rsbg_pkg::OP_PLAY) begin
              if (pending_sound == rsbg_pkg::PEND_NONE) begin
                pending_sound <= (cmd.sound == rsbg_pkg::SOUND_PRESS) ?
                                 rsbg_pkg::PEND_PRESS : rsbg_pkg::PEND_MOVE;
              end
            end else begin
              if (!playing && pending_sound != rsbg_pkg::PEND_NONE) begin
                active_sound      <= (pending_sound == rsbg_pkg::PEND_PRESS) ?
                                     rsbg_pkg::SOUND_PRESS : rsbg_pkg::SOUND_MOVE;
                pending_sound     <= rsbg_pkg::PEND_NONE;
                playing           <= 1'b1;
                position          <= '0;
                half_period_count <= '0;
                wave_phase        <= 1'b0;
              end
              state <= ST_EVAL;
            end
          end
        end

        // Decide silence, end of beep and which ramps apply.
        ST_EVAL: begin
          if (!playing) begin
            silent <= 1'b1;
            state  <= ST_OUT;
          end else if (position >= len_sel) begin
            playing           <= 1'b0;
            position          <= '0;
            half_period_count <= '0;
            wave_phase        <= 1'b0;
            silent            <= 1'b1;
            state             <= ST_OUT;
          end else begin
            silent <= 1'b0;
            mag    <= amplitude;
            do_in  <= (position < RAMP);
            do_out <= (len_sel > RAMP) && (remain < RAMP);
            tail   <= remain[FW-1:0];
            if ((position < RAMP) || ((len_sel > RAMP) && (remain < RAMP))) begin
              state <= ST_MUL;
            end else begin
              state <= ST_OUT;
            end
          end
        end

        // Magnitude times the ramp factor.
        ST_MUL: begin
          prod  <= mul_out[P_W-1:0];
          state <= ST_DIV;
        end

        // Truncating division by RAMP_LEN; fade out follows fade in if both apply.
        ST_DIV: begin
          mag <= mul_out[K +: rsbg_pkg::AMP_W];
          if (do_in && do_out) begin
            do_in <= 1'b0;
            state <= ST_MUL;
          end else begin
            do_in  <= 1'b0;
            do_out <= 1'b0;
            state  <= ST_OUT;
          end
        end

        // Issue the item once the output register is free, then advance.
        ST_OUT: begin
          if (!smp_valid || !smp_stall) begin
            smp_valid    <= 1'b1;
            smp.sample   <= silent ? 16'sd0 : wave_value;
            smp.busy_res <= !silent;
            if (!silent) begin
              if (pos_inc >= len_sel) begin
                playing           <= 1'b0;
                position          <= '0;
                half_period_count <= '0;
                wave_phase        <= 1'b0;
              end else begin
                position <= pos_inc;
                if (hpc_wrap) begin
                  half_period_count <= '0;
                  wave_phase        <= !wave_phase;
                end else begin
                  half_period_count <= hpc_inc;
                end
              end
            end
            state <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ bench/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the ramped square beep generator. A clocked driver
// feeds command items from a backlog, and a clocked monitor compares every
// sample item with the oldest sample predicted by an in-bench model of the
// click player. Settings are reprogrammed between phases.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned RAMP = 40;

  logic                            clk       = 1'b0;
  logic                            rst       = 1'b1;
  logic                            cmd_valid = 1'b0;
  logic                            cmd_stall;
  rsbg_pkg::cmd_t                  cmd       = '0;
  logic                            smp_valid;
  logic                            smp_stall = 1'b0;
  rsbg_pkg::smp_t                  smp;
  logic                            cfg_write = 1'b0;
  logic [rsbg_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [rsbg_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  // Items waiting to be driven and samples waiting to arrive.
  rsbg_pkg::cmd_t cmd_backlog[$];
  rsbg_pkg::smp_t expected_samples[$];
  rsbg_pkg::smp_t oldest_sample;
  int unsigned    mismatches = 0;
  bit             steady     = 1'b0;

  // Model copy of the settings.
  logic [rsbg_pkg::HP_W-1:0]  cfg_move_hp   = rsbg_pkg::RST_MOVE_HALF_PERIOD;
  logic [rsbg_pkg::LEN_W-1:0] cfg_move_len  = rsbg_pkg::RST_MOVE_LENGTH;
  logic [rsbg_pkg::HP_W-1:0]  cfg_press_hp  = rsbg_pkg::RST_PRESS_HALF_PERIOD;
  logic [rsbg_pkg::LEN_W-1:0] cfg_press_len = rsbg_pkg::RST_PRESS_LENGTH;
  logic [rsbg_pkg::AMP_W-1:0] cfg_amp       = rsbg_pkg::RST_AMPLITUDE;

  // Model copy of the player state.
  logic [1:0]                 pend_click = rsbg_pkg::PEND_NONE;
  logic                       beep_on    = 1'b0;
  logic                       beep_sound = rsbg_pkg::SOUND_MOVE;
  logic [rsbg_pkg::LEN_W-1:0] beep_pos   = '0;
  logic [rsbg_pkg::HP_W-1:0]  half_count = '0;
  logic                       wave_hi    = 1'b0;

  ramped_square_beep_generator_core #(
    .RAMP_LEN (RAMP)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .smp_valid (smp_valid),
    .smp_stall (smp_stall),
    .smp       (smp),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // Random idling on either side, switched off during the steady stretch.
  function automatic bit idle_now();
    return !steady && ($urandom_range(99) < 38);
  endfunction

  function automatic void stop_beep();
    beep_on    = 1'b0;
    beep_pos   = '0;
    half_count = '0;
    wave_hi    = 1'b0;
  endfunction

  // Advance the player model by one command item and queue any sample it gives.
  function automatic void advance_beep_model(input rsbg_pkg::cmd_t c);
    int unsigned    len;
    int unsigned    hp;
    int unsigned    mag;
    int unsigned    pos;
    logic [15:0]    m16;
    rsbg_pkg::smp_t res;
    res = '0;
    if (c.operation == rsbg_pkg::OP_PLAY) begin
      if (pend_click == rsbg_pkg::PEND_NONE) begin
        pend_click = (c.sound == rsbg_pkg::SOUND_PRESS) ?
                     rsbg_pkg::PEND_PRESS : rsbg_pkg::PEND_MOVE;
      end
      return;
    end
    // An idle player picks up the pending click on this very tick.
    if (!beep_on && pend_click != rsbg_pkg::PEND_NONE) begin
      beep_sound = (pend_click == rsbg_pkg::PEND_PRESS) ?
                   rsbg_pkg::SOUND_PRESS : rsbg_pkg::SOUND_MOVE;
      pend_click = rsbg_pkg::PEND_NONE;
      beep_on    = 1'b1;
      beep_pos   = '0;
      half_count = '0;
      wave_hi    = 1'b0;
    end
    if (!beep_on) begin
      expected_samples.push_back(res);
      return;
    end
    len = 32'((beep_sound == rsbg_pkg::SOUND_PRESS) ? cfg_press_len : cfg_move_len);
    hp  = 32'((beep_sound == rsbg_pkg::SOUND_PRESS) ? cfg_press_hp : cfg_move_hp);
    if (hp == 0) begin
      hp = 1;
    end
    pos = 32'(beep_pos);
    // A length at or below the position ends the beep with silence.
    if (pos >= len) begin
      stop_beep();
      expected_samples.push_back(res);
      return;
    end
    mag = 32'(cfg_amp);
    if (pos < RAMP) begin
      mag = (mag * pos) / RAMP;
    end
    if (len > RAMP && pos > len - RAMP) begin
      mag = (mag * (len - pos)) / RAMP;
    end
    m16 = mag[15:0];
    res.sample   = wave_hi ? m16 : (16'd0 - m16);
    res.busy_res = 1'b1;
    half_count = half_count + 12'd1;
    if (half_count >= hp || half_count == 0) begin
      half_count = '0;
      wave_hi    = ~wave_hi;
    end
    beep_pos = rsbg_pkg::LEN_W'(pos + 1);
    if (pos + 1 >= len) begin
      stop_beep();
    end
    expected_samples.push_back(res);
  endfunction

  // Command driver: holds a stalled item, otherwise takes the next one or idles.
  always @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else begin
      if (cmd_valid && !cmd_stall) begin
        advance_beep_model(cmd);
      end
      if (!cmd_valid || !cmd_stall) begin
        if (cmd_backlog.size() != 0 && !idle_now()) begin
          cmd_valid <= 1'b1;
          cmd       <= cmd_backlog.pop_front();
        end else begin
          cmd_valid <= 1'b0;
        end
      end
    end
  end

  // Sample monitor: checks each accepted item against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && smp_valid && !smp_stall) begin
      if (expected_samples.size() == 0) begin
        $error("unexpected sample item: sample %0d busy_res %0b", smp.sample, smp.busy_res);
        mismatches++;
      end else begin
        oldest_sample = expected_samples.pop_front();
        if (smp.sample !== oldest_sample.sample) begin
          $error("sample: expected %0d, got %0d", oldest_sample.sample, smp.sample);
          mismatches++;
        end
        if (smp.busy_res !== oldest_sample.busy_res) begin
          $error("busy_res: expected %0b, got %0b", oldest_sample.busy_res, smp.busy_res);
          mismatches++;
        end
      end
    end
    smp_stall <= rst ? 1'b0 : idle_now();
  end

  task automatic queue_item(input logic op, input logic snd);
    rsbg_pkg::cmd_t c;
    c.operation = op;
    c.sound     = snd;
    cmd_backlog.push_back(c);
  endtask

  // Wait until every item is driven and every sample has arrived, then let
  // the block finish any work in progress.
  task automatic wait_quiet();
    do begin
      @(negedge clk);
    end while (cmd_backlog.size() != 0 || cmd_valid || expected_samples.size() != 0);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(input logic [rsbg_pkg::CFG_IDX_W-1:0] idx,
                           input logic [rsbg_pkg::CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      rsbg_pkg::CFG_MOVE_HALF_PERIOD:  cfg_move_hp   = data[rsbg_pkg::HP_W-1:0];
      rsbg_pkg::CFG_MOVE_LENGTH:       cfg_move_len  = data[rsbg_pkg::LEN_W-1:0];
      rsbg_pkg::CFG_PRESS_HALF_PERIOD: cfg_press_hp  = data[rsbg_pkg::HP_W-1:0];
      rsbg_pkg::CFG_PRESS_LENGTH:      cfg_press_len = data[rsbg_pkg::LEN_W-1:0];
      rsbg_pkg::CFG_AMPLITUDE:         cfg_amp       = data[rsbg_pkg::AMP_W-1:0];
      default: ;
    endcase
  endtask

  // Program all five registers on consecutive cycles.
  task automatic apply_settings(input logic [15:0] mhp, input logic [15:0] mlen,
                                input logic [15:0] php, input logic [15:0] plen,
                                input logic [15:0] amp);
    write_reg(rsbg_pkg::CFG_MOVE_HALF_PERIOD, mhp);
    write_reg(rsbg_pkg::CFG_MOVE_LENGTH, mlen);
    write_reg(rsbg_pkg::CFG_PRESS_HALF_PERIOD, php);
    write_reg(rsbg_pkg::CFG_PRESS_LENGTH, plen);
    write_reg(rsbg_pkg::CFG_AMPLITUDE, amp);
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  function automatic logic [15:0] pick_half_period();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 8) return {4'($urandom), 12'd0};
    if (r < 16) return {4'($urandom), 12'd4095};
    if (r < 26) return {4'($urandom), 12'd1};
    return {4'($urandom), 12'($urandom_range(20, 2))};
  endfunction

  // Mostly short clicks that finish within a phase; a few long ones that
  // are cut short by the next phase's settings.
  function automatic logic [15:0] pick_length();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 6) return 16'd0;
    if (r < 12) return 16'd1;
    if (r < 24) return 16'($urandom_range(RAMP + 2, RAMP - 2));
    if (r < 28) return 16'd65535;
    if (r < 32) return 16'($urandom_range(65534, 1000));
    return 16'($urandom_range(120, 2));
  endfunction

  function automatic logic [15:0] pick_amplitude();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return {1'($urandom), 15'd0};
    if (r < 20) return {1'($urandom), 15'd32767};
    if (r < 28) return {1'($urandom), 15'd1};
    return {1'($urandom), 15'($urandom_range(32767, 0))};
  endfunction

  // Mostly a request followed by a run of ticks, with some loose items mixed in.
  task automatic queue_random_phase(input int unsigned n);
    int unsigned count;
    int unsigned ticks;
    count = 0;
    while (count < n) begin
      if ($urandom_range(99) < 75) begin
        queue_item(rsbg_pkg::OP_PLAY, 1'($urandom));
        ticks = $urandom_range(130, 4);
        repeat (ticks) queue_item(rsbg_pkg::OP_TICK, 1'($urandom));
        count += ticks + 1;
      end else begin
        queue_item(1'($urandom), 1'($urandom));
        count++;
      end
    end
  endtask

  // Main sequence: directed checks, then randomised phases.
  initial begin
    int unsigned phase;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Silence, a move click latched, a press request ignored while pending.
    queue_item(rsbg_pkg::OP_TICK, rsbg_pkg::SOUND_PRESS);
    queue_item(rsbg_pkg::OP_PLAY, rsbg_pkg::SOUND_MOVE);
    queue_item(rsbg_pkg::OP_PLAY, rsbg_pkg::SOUND_PRESS);
    repeat (5) queue_item(rsbg_pkg::OP_TICK, rsbg_pkg::SOUND_MOVE);
    wait_quiet();

    // Shrink the move length under the current position, zero half period,
    // full amplitude, zero press length and the longest press half period.
    apply_settings(16'd0, 16'd3, 16'd4095, 16'd0, 16'd32767);
    queue_item(rsbg_pkg::OP_TICK, rsbg_pkg::SOUND_MOVE);
    queue_item(rsbg_pkg::OP_PLAY, rsbg_pkg::SOUND_PRESS);
    queue_item(rsbg_pkg::OP_TICK, rsbg_pkg::SOUND_MOVE);
    queue_item(rsbg_pkg::OP_PLAY, rsbg_pkg::SOUND_MOVE);
    repeat (4) queue_item(rsbg_pkg::OP_TICK, rsbg_pkg::SOUND_PRESS);
    wait_quiet();

    for (phase = 0; phase < 10; phase++) begin
      apply_settings(pick_half_period(), pick_length(), pick_half_period(),
                     pick_length(), pick_amplitude());
      steady = (phase == 3);
      queue_random_phase(100);
      wait_quiet();
    end
    steady = 1'b0;

    if (mismatches == 0 && expected_samples.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #10000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
